// ===== rtl/triangle_row_rasterizer_assert.svh =====
// Assertion macros shared by the triangle row rasterizer RTL.
`ifndef TRIANGLE_ROW_RASTERIZER_ASSERT_SVH
`define TRIANGLE_ROW_RASTERIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TRR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("trr assertion failed");
`define TRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trr assertion failed");
`define TRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trr assertion failed");
`else
`define TRR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define TRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/trr_pkg.sv =====
// Shared constants and the triangle job type of the row rasterizer.
package trr_pkg;

    localparam int MAX_CANVAS_DEF = 64;
    localparam logic [6:0] CANVAS_RESET = 7'd50;
    localparam int MIN_AREA = 2;
    localparam int QUEUE_DEPTH = 2;

    // One accepted, non-culled triangle with its edge values at column 0 of the first row.
    typedef struct packed {
        logic signed [15:0] base1;
        logic signed [15:0] base2;
        logic signed [15:0] base3;
        logic signed [6:0]  dx1;
        logic signed [6:0]  dy1;
        logic signed [6:0]  dx2;
        logic signed [6:0]  dy2;
        logic signed [6:0]  dx3;
        logic signed [6:0]  dy3;
        logic [5:0]         lo_x;
        logic [5:0]         hi_x;
        logic [5:0]         lo_y;
        logic [5:0]         hi_y;
        logic [15:0]        color;
    } job_t;

endpackage

// ===== rtl/triangle_row_rasterizer.sv =====
// Top level of the triangle row rasterizer: canvas register, front end, queue, row engine.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_data (grid_dim, 7 bits)
//  in       | in_valid/in_stall    | x1 y1 x2 y2 x3 y3 fill_color
//  out      | out_valid/out_stall  | row coverage pixel_color last_row
//
// Front end works on one triangle at a time: capture, multiply, then cull and enqueue.
// Row engine loads a job from the queue, then emits its rows in order from the top of the box.
// A two-entry job queue lets the front end take new triangles while rows stream out.
// Reset sets grid_dim to 50 and empties the queue; cfg writes are always ready.
// out_stall holds the output register; the engine and then the queue back up behind it.
module triangle_row_rasterizer #(
    parameter int MAX_CANVAS = trr_pkg::MAX_CANVAS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  x1,
    input  logic [5:0]  y1,
    input  logic [5:0]  x2,
    input  logic [5:0]  y2,
    input  logic [5:0]  x3,
    input  logic [5:0]  y3,
    input  logic [15:0] fill_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  row,
    output logic [63:0] coverage,
    output logic [15:0] pixel_color,
    output logic        last_row
);

    logic [6:0]    grid_dim_reg;
    logic          push, pop, q_full, q_empty;
    trr_pkg::job_t wr_job, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_dim_reg <= trr_pkg::CANVAS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            grid_dim_reg <= cfg_data;
        end
    end

    trr_front #(
        .MAX_CANVAS (MAX_CANVAS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x1          (x1),
        .y1          (y1),
        .x2          (x2),
        .y2          (y2),
        .x3          (x3),
        .y3          (y3),
        .fill_color  (fill_color),
        .grid_dim    (grid_dim_reg),
        .q_full      (q_full),
        .push        (push),
        .job         (wr_job)
    );

    trr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .full   (q_full),
        .empty  (q_empty)
    );

    trr_back #(
        .MAX_CANVAS (MAX_CANVAS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row         (row),
        .coverage    (coverage),
        .pixel_color (pixel_color),
        .last_row    (last_row)
    );

endmodule

// ===== rtl/trr_front.sv =====
// Front end: takes a triangle, culls it, clamps its box and builds a row job.
module trr_front #(
    parameter int MAX_CANVAS = trr_pkg::MAX_CANVAS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [5:0]        x1,
    input  logic [5:0]        y1,
    input  logic [5:0]        x2,
    input  logic [5:0]        y2,
    input  logic [5:0]        x3,
    input  logic [5:0]        y3,
    input  logic [15:0]       fill_color,
    input  logic [6:0]        grid_dim,
    input  logic              q_full,
    output logic              push,
    output trr_pkg::job_t     job
);

    typedef enum logic [1:0] {FR_IDLE, FR_CALC, FR_PUSH} fr_state_t;

    fr_state_t state_reg;
    logic [5:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [15:0] color_reg;

    logic signed [13:0] pa_reg, pb_reg;
    logic signed [13:0] ea1_reg, eb1_reg, ea2_reg, eb2_reg, ea3_reg, eb3_reg;
    logic [5:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic       empty_reg;

    logic signed [6:0] dx1, dy1, dx2, dy2, dx3, dy3;
    logic signed [6:0] ax, ay;
    logic signed [6:0] ry1, ry2, ry3;
    logic [5:0] min_x, max_x, min_y, max_y;
    logic [6:0] size, size_m1;
    logic [5:0] hi_x_c, hi_y_c;
    logic       size_zero;
    logic signed [14:0] area;
    logic       cull;

    function automatic logic [5:0] min3(logic [5:0] a, logic [5:0] b, logic [5:0] c);
        logic [5:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [5:0] max3(logic [5:0] a, logic [5:0] b, logic [5:0] c);
        logic [5:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign dx1 = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign dy1 = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
    assign dx2 = $signed({1'b0, x3_reg}) - $signed({1'b0, x2_reg});
    assign dy2 = $signed({1'b0, y3_reg}) - $signed({1'b0, y2_reg});
    assign dx3 = $signed({1'b0, x1_reg}) - $signed({1'b0, x3_reg});
    assign dy3 = $signed({1'b0, y1_reg}) - $signed({1'b0, y3_reg});
    assign ax  = $signed({1'b0, x3_reg}) - $signed({1'b0, x1_reg});
    assign ay  = $signed({1'b0, y3_reg}) - $signed({1'b0, y1_reg});

    assign min_x = min3(x1_reg, x2_reg, x3_reg);
    assign max_x = max3(x1_reg, x2_reg, x3_reg);
    assign min_y = min3(y1_reg, y2_reg, y3_reg);
    assign max_y = max3(y1_reg, y2_reg, y3_reg);

    assign size      = (grid_dim > 7'(MAX_CANVAS)) ? 7'(MAX_CANVAS) : grid_dim;
    assign size_zero = (size == 7'd0);
    assign size_m1   = size - 7'd1;
    assign hi_x_c    = ({1'b0, max_x} > size_m1) ? size_m1[5:0] : max_x;
    assign hi_y_c    = ({1'b0, max_y} > size_m1) ? size_m1[5:0] : max_y;

    // Row offset from each vertex to the first row of the box
    assign ry1 = $signed({1'b0, min_y}) - $signed({1'b0, y1_reg});
    assign ry2 = $signed({1'b0, min_y}) - $signed({1'b0, y2_reg});
    assign ry3 = $signed({1'b0, min_y}) - $signed({1'b0, y3_reg});

    assign area = {pa_reg[13], pa_reg} - {pb_reg[13], pb_reg};
    assign cull = (area < $signed(15'(trr_pkg::MIN_AREA))) || empty_reg;

    assign in_stall = (state_reg != FR_IDLE);
    assign push     = (state_reg == FR_PUSH) && !cull && !q_full;

    always_comb
    begin
        job.base1 = 16'sd0 - {{2{ea1_reg[13]}}, ea1_reg} - {{2{eb1_reg[13]}}, eb1_reg};
        job.base2 = 16'sd0 - {{2{ea2_reg[13]}}, ea2_reg} - {{2{eb2_reg[13]}}, eb2_reg};
        job.base3 = 16'sd0 - {{2{ea3_reg[13]}}, ea3_reg} - {{2{eb3_reg[13]}}, eb3_reg};
        job.dx1   = dx1;
        job.dy1   = dy1;
        job.dx2   = dx2;
        job.dy2   = dy2;
        job.dx3   = dx3;
        job.dy3   = dy3;
        job.lo_x  = lo_x_reg;
        job.hi_x  = hi_x_reg;
        job.lo_y  = lo_y_reg;
        job.hi_y  = hi_y_reg;
        job.color = color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            x1_reg    <= '0;
            y1_reg    <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            x3_reg    <= '0;
            y3_reg    <= '0;
            color_reg <= '0;
            pa_reg    <= '0;
            pb_reg    <= '0;
            ea1_reg   <= '0;
            eb1_reg   <= '0;
            ea2_reg   <= '0;
            eb2_reg   <= '0;
            ea3_reg   <= '0;
            eb3_reg   <= '0;
            lo_x_reg  <= '0;
            hi_x_reg  <= '0;
            lo_y_reg  <= '0;
            hi_y_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                FR_IDLE:
                begin
                    if (in_valid)
                    begin
                        x1_reg    <= x1;
                        y1_reg    <= y1;
                        x2_reg    <= x2;
                        y2_reg    <= y2;
                        x3_reg    <= x3;
                        y3_reg    <= y3;
                        color_reg <= fill_color;
                        state_reg <= FR_CALC;
                    end
                end
                FR_CALC:
                begin
                    pa_reg    <= dx1 * ay;
                    pb_reg    <= dy1 * ax;
                    ea1_reg   <= $signed({1'b0, x1_reg}) * dy1;
                    eb1_reg   <= ry1 * dx1;
                    ea2_reg   <= $signed({1'b0, x2_reg}) * dy2;
                    eb2_reg   <= ry2 * dx2;
                    ea3_reg   <= $signed({1'b0, x3_reg}) * dy3;
                    eb3_reg   <= ry3 * dx3;
                    lo_x_reg  <= min_x;
                    hi_x_reg  <= hi_x_c;
                    lo_y_reg  <= min_y;
                    hi_y_reg  <= hi_y_c;
                    // an empty column range still gives blank rows; only rows decide
                    empty_reg <= size_zero || (min_y > hi_y_c);
                    state_reg <= FR_PUSH;
                end
                FR_PUSH:
                begin
                    if (cull || !q_full)
                    begin
                        state_reg <= FR_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= FR_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/trr_queue.sv =====
// Short job queue between the front end and the row engine.
`include "triangle_row_rasterizer_assert.svh"

module trr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  trr_pkg::job_t wr_job,
    input  logic          pop,
    output trr_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = trr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trr_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            priority if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `TRR_ASSERT_NEVER(a_q_overflow, clk, rst_n, push && full)
    `TRR_ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && empty)

endmodule

// ===== rtl/trr_back.sv =====
// Row engine: steps the edge values down the box and emits one coverage mask a cycle unless out_stall holds it.
`include "triangle_row_rasterizer_assert.svh"

module trr_back #(
    parameter int MAX_CANVAS = trr_pkg::MAX_CANVAS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  trr_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [5:0]    row,
    output logic [63:0]   coverage,
    output logic [15:0]   pixel_color,
    output logic          last_row
);

    typedef enum logic {BK_IDLE, BK_RUN} bk_state_t;

    bk_state_t     state_reg;
    trr_pkg::job_t job_reg;
    logic [5:0]    y_reg;
    logic signed [15:0] b1_reg, b2_reg, b3_reg;

    logic          out_valid_reg;
    logic [5:0]    row_reg;
    logic [63:0]   coverage_reg;
    logic [15:0]   color_reg;
    logic          last_row_reg;

    logic signed [15:0] dx1_w, dy1_w, dx2_w, dy2_w, dx3_w, dy3_w;
    logic [63:0] cov;
    logic        emit;
    logic        at_last;

    assign dx1_w = {{9{job_reg.dx1[6]}}, job_reg.dx1};
    assign dy1_w = {{9{job_reg.dy1[6]}}, job_reg.dy1};
    assign dx2_w = {{9{job_reg.dx2[6]}}, job_reg.dx2};
    assign dy2_w = {{9{job_reg.dy2[6]}}, job_reg.dy2};
    assign dx3_w = {{9{job_reg.dx3[6]}}, job_reg.dx3};
    assign dy3_w = {{9{job_reg.dy3[6]}}, job_reg.dy3};

    // One lane per canvas column; each adds its column times the edge slope
    for (genvar c = 0; c < 64; c++)
    begin : g_lane
        if (c < MAX_CANVAS)
        begin : g_live
            localparam logic signed [15:0] LX = 16'(c);
            logic signed [15:0] e1, e2, e3;
            logic all_ge, all_le, in_box;

            assign e1     = b1_reg + dy1_w * LX;
            assign e2     = b2_reg + dy2_w * LX;
            assign e3     = b3_reg + dy3_w * LX;
            assign all_ge = !e1[15] && !e2[15] && !e3[15];
            assign all_le = (e1[15] || (e1 == 16'sd0)) &&
                            (e2[15] || (e2 == 16'sd0)) &&
                            (e3[15] || (e3 == 16'sd0));
            assign in_box = (6'(c) >= job_reg.lo_x) && (6'(c) <= job_reg.hi_x);
            assign cov[c] = in_box && (all_ge || all_le);
        end
        else
        begin : g_dead
            assign cov[c] = 1'b0;
        end
    end

    assign at_last = (y_reg == job_reg.hi_y);
    assign emit    = (state_reg == BK_RUN) && (!out_valid_reg || !out_stall);
    assign pop     = (state_reg == BK_IDLE) && !q_empty;

    assign out_valid   = out_valid_reg;
    assign row         = row_reg;
    assign coverage    = coverage_reg;
    assign pixel_color = color_reg;
    assign last_row    = last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            job_reg       <= '0;
            y_reg         <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            b3_reg        <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            coverage_reg  <= '0;
            color_reg     <= '0;
            last_row_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                BK_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg   <= head;
                        y_reg     <= head.lo_y;
                        b1_reg    <= head.base1;
                        b2_reg    <= head.base2;
                        b3_reg    <= head.base3;
                        state_reg <= BK_RUN;
                    end
                end
                BK_RUN:
                begin
                    if (emit)
                    begin
                        row_reg      <= y_reg;
                        coverage_reg <= cov;
                        color_reg    <= job_reg.color;
                        last_row_reg <= at_last;
                        if (at_last)
                        begin
                            state_reg <= BK_IDLE;
                        end
                        else
                        begin
                            // moving down one row subtracts dx from each edge
                            y_reg  <= y_reg + 6'd1;
                            b1_reg <= b1_reg - dx1_w;
                            b2_reg <= b2_reg - dx2_w;
                            b3_reg <= b3_reg - dx3_w;
                        end
                    end
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    `TRR_ASSERT_IMP(a_bk_row_in_box, clk, rst_n, state_reg == BK_RUN, y_reg <= job_reg.hi_y)
    `TRR_ASSERT_NXT(a_bk_last_drains, clk, rst_n, out_valid_reg && !out_stall && last_row_reg && (state_reg == BK_IDLE), !out_valid_reg)

endmodule
